// File: rtl/sukt_pkg.sv
// Shared types, codes and constants of the sorted unique-key table.
`timescale 1ns / 1ps

package sukt_pkg;

  // Default table depth and the most results one dump gives
  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned MAX_RESULTS  = 32;

  // Field widths
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STS_W  = 3;
  localparam int unsigned POS_W  = 6;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT  = 3'd0,
    REQ_DELETE  = 3'd1,
    REQ_SEARCH  = 3'd2,
    REQ_DUMP_UP = 3'd3,
    REQ_DUMP_DN = 3'd4
  } req_e;

  // Result status codes
  typedef enum logic [STS_W-1:0] {
    STS_DONE     = 3'd0,
    STS_FOUND    = 3'd1,
    STS_DUP      = 3'd2,
    STS_NOTFOUND = 3'd3,
    STS_EMPTY    = 3'd4,
    STS_FULL     = 3'd5
  } status_e;

  // One stored entry: key and three payload words
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
  } entry_t;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCAN,
    CMD_SHIFT,
    CMD_PUT,
    CMD_DUMP_RD,
    CMD_DUMP_OUT,
    CMD_RESP
  } cmd_e;

  typedef struct packed {
    cmd_e    op;
    logic    ins;   // request is an insert (shift direction)
    logic    desc;  // dump walks from the top entry down
    status_e code;  // status of a single response beat
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_done;
    logic scan_hit;
    logic shift_done;
    logic out_free;
    logic dump_last;
  } dp_stat_t;

endpackage

// File: rtl/sukt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sukt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds while idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sukt_dp.sv
// Datapath: entry RAM, entry count, walk pointers and the result register.
`timescale 1ns / 1ps

module sukt_dp import sukt_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  input  logic signed [KEY_W-1:0]  key_i,
  input  logic [DATA_W-1:0]        payload_a_i,
  input  logic [DATA_W-1:0]        payload_b_i,
  input  logic [DATA_W-1:0]        payload_c_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic [STS_W-1:0]         status_o,
  output logic signed [KEY_W-1:0]  key_out_o,
  output logic [DATA_W-1:0]        data_a_o,
  output logic [DATA_W-1:0]        data_b_o,
  output logic [DATA_W-1:0]        data_c_o,
  output logic [POS_W-1:0]         position_o,
  output logic                     last_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Control registers
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] lb_q, lb_d;
  logic [CW-1:0] j_q, j_d;
  logic [AW-1:0] wa_q, wa_d;
  logic          rv_q, rv_d;
  logic          out_valid_q, out_valid_d;

  // Payload registers
  entry_t        req_q;
  entry_t        out_q, out_d;
  status_e       out_sts_q, out_sts_d;
  logic [POS_W-1:0] out_pos_q, out_pos_d;
  logic          out_last_q, out_last_d;

  // RAM ports
  logic          re, we;
  logic [AW-1:0] raddr, waddr;
  entry_t        wdata, rdata;

  // Walk helpers
  logic          ge, hit, scan_done, shift_done, out_free, dump_last, load_out;
  logic [CW-1:0] lb_nx, ptr_dn, ptr_up, n_dump, j_nx, idx_cur, idx_nx;
  logic [CW:0]   pos_full;

  sukt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Lower-bound scan: stop at the first entry not below the key
  assign ge        = rv_q && ($signed(rdata.key) >= $signed(req_q.key));
  assign hit       = ge && (rdata.key == req_q.key);
  assign scan_done = ge || (ptr_q == count_q);
  assign lb_nx     = ge ? ptr_dn : count_q;
  assign ptr_dn    = ptr_q - 1'b1;
  assign ptr_up    = ptr_q + 1'b1;

  // Shift ends at the hole (insert) or at the top entry (delete)
  assign shift_done = cmd_i.ins ? (ptr_q == lb_q) : (ptr_q == count_q);

  // Dump walk: index and ascending rank of the entry being reported
  assign n_dump    = ((CAPACITY > MAX_RESULTS) && (count_q > CW'(MAX_RESULTS)))
                     ? CW'(MAX_RESULTS) : count_q;
  assign j_nx      = j_q + 1'b1;
  assign dump_last = (j_nx == n_dump);
  assign idx_cur   = cmd_i.desc ? (count_q - 1'b1 - j_q)  : j_q;
  assign idx_nx    = cmd_i.desc ? (count_q - 1'b1 - j_nx) : j_nx;
  assign pos_full  = {1'b0, idx_cur} + 1'b1;

  assign out_free  = !out_valid_q || !out_stall_i;

  // Operation decode
  always_comb begin
    count_d    = count_q;
    ptr_d      = ptr_q;
    lb_d       = lb_q;
    j_d        = j_q;
    wa_d       = wa_q;
    rv_d       = rv_q;
    re         = 1'b0;
    we         = 1'b0;
    raddr      = '0;
    waddr      = wa_q;
    wdata      = rdata;
    load_out   = 1'b0;
    out_d      = rdata;
    out_sts_d  = STS_FOUND;
    out_pos_d  = '0;
    out_last_d = 1'b1;
    unique case (cmd_i.op)
      CMD_NONE: begin
      end
      CMD_LOAD: begin
        ptr_d = '0;
        j_d   = '0;
        rv_d  = 1'b0;
      end
      CMD_SCAN: begin
        if (scan_done) begin
          lb_d  = lb_nx;
          ptr_d = cmd_i.ins ? count_q : (lb_nx + 1'b1);
          rv_d  = 1'b0;
        end else begin
          re    = 1'b1;
          raddr = ptr_q[AW-1:0];
          ptr_d = ptr_up;
          rv_d  = 1'b1;
        end
      end
      CMD_SHIFT: begin
        // write back the entry read last cycle one slot over
        if (rv_q) begin
          we    = 1'b1;
          waddr = wa_q;
          wdata = rdata;
        end
        if (!shift_done) begin
          re    = 1'b1;
          raddr = cmd_i.ins ? ptr_dn[AW-1:0] : ptr_q[AW-1:0];
          wa_d  = cmd_i.ins ? ptr_q[AW-1:0]  : ptr_dn[AW-1:0];
          ptr_d = cmd_i.ins ? ptr_dn : ptr_up;
          rv_d  = 1'b1;
        end else begin
          rv_d = 1'b0;
          if (!cmd_i.ins) begin
            count_d = count_q - 1'b1;
          end
        end
      end
      CMD_PUT: begin
        we      = 1'b1;
        waddr   = lb_q[AW-1:0];
        wdata   = req_q;
        count_d = count_q + 1'b1;
      end
      CMD_DUMP_RD: begin
        re    = 1'b1;
        raddr = idx_cur[AW-1:0];
      end
      CMD_DUMP_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_pos_d  = POS_W'(pos_full);
          out_last_d = dump_last;
          if (!dump_last) begin
            j_d   = j_nx;
            re    = 1'b1;
            raddr = idx_nx[AW-1:0];
          end
        end
      end
      CMD_RESP: begin
        if (out_free) begin
          load_out  = 1'b1;
          out_sts_d = cmd_i.code;
          out_d     = (cmd_i.code == STS_FOUND) ? rdata : '0;
        end
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      lb_q        <= '0;
      j_q         <= '0;
      wa_q        <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      lb_q        <= lb_d;
      j_q         <= j_d;
      wa_q        <= wa_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_LOAD) begin
      req_q <= '{key: key_i, a: payload_a_i, b: payload_b_i, c: payload_c_i};
    end
    if (load_out) begin
      out_q      <= out_d;
      out_sts_q  <= out_sts_d;
      out_pos_q  <= out_pos_d;
      out_last_q <= out_last_d;
    end
  end

  assign stat_o = '{
    full:       (count_q == CW'(CAPACITY)),
    empty:      (count_q == '0),
    scan_done:  scan_done,
    scan_hit:   hit,
    shift_done: shift_done,
    out_free:   out_free,
    dump_last:  dump_last
  };

  assign out_valid_o = out_valid_q;
  assign status_o    = out_sts_q;
  assign key_out_o   = $signed(out_q.key);
  assign data_a_o    = out_q.a;
  assign data_b_o    = out_q.b;
  assign data_c_o    = out_q.c;
  assign position_o  = out_pos_q;
  assign last_o      = out_last_q;

  // Count never passes the table depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Count moves by at most one entry per cycle
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 ||
              count_q == $past(count_q) - 1'b1))
    else $error("entry count jumped");

  // A shift never reads the slot it writes in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (waddr != raddr))
    else $error("read and write at the same slot");

endmodule

// File: rtl/sukt_ctrl.sv
// Controller: sequences scan, shift, store, dump and response beats.
`timescale 1ns / 1ps

module sukt_ctrl import sukt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [REQ_W-1:0] req_type_i,
  output logic             in_stall_o,
  output dp_cmd_t          cmd_o,
  input  dp_stat_t         stat_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PUT,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESP
  } state_e;

  state_e  state_q, state_d;
  req_e    req_q, req_d;
  status_e code_q, code_d;
  req_e    req_in;
  cmd_e    op;

  assign req_in = req_e'(req_type_i);

  // Next state and command
  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    code_d  = code_q;
    op      = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op    = CMD_LOAD;
          req_d = req_in;
          unique case (req_in)
            REQ_INSERT: begin
              if (stat_i.full) begin
                code_d  = STS_FULL;
                state_d = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            REQ_DELETE, REQ_SEARCH: begin
              if (stat_i.empty) begin
                code_d  = STS_EMPTY;
                state_d = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            REQ_DUMP_UP, REQ_DUMP_DN: begin
              if (stat_i.empty) begin
                code_d  = STS_EMPTY;
                state_d = S_RESP;
              end else begin
                state_d = S_DUMP_RD;
              end
            end
            default: begin
              // unused request kinds are dropped without a result
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        op = CMD_SCAN;
        if (stat_i.scan_done) begin
          unique case (req_q)
            REQ_INSERT: begin
              if (stat_i.scan_hit) begin
                code_d  = STS_DUP;
                state_d = S_RESP;
              end else begin
                state_d = S_SHIFT;
              end
            end
            REQ_DELETE: begin
              if (stat_i.scan_hit) begin
                state_d = S_SHIFT;
              end else begin
                code_d  = STS_NOTFOUND;
                state_d = S_RESP;
              end
            end
            default: begin
              code_d  = stat_i.scan_hit ? STS_FOUND : STS_NOTFOUND;
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_SHIFT: begin
        op = CMD_SHIFT;
        if (stat_i.shift_done) begin
          if (req_q == REQ_INSERT) begin
            state_d = S_PUT;
          end else begin
            code_d  = STS_DONE;
            state_d = S_RESP;
          end
        end
      end
      S_PUT: begin
        op      = CMD_PUT;
        code_d  = STS_DONE;
        state_d = S_RESP;
      end
      S_DUMP_RD: begin
        op      = CMD_DUMP_RD;
        state_d = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        op = CMD_DUMP_OUT;
        if (stat_i.out_free && stat_i.dump_last) begin
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        op = CMD_RESP;
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and held request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= REQ_INSERT;
      code_q  <= STS_DONE;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
      code_q  <= code_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o      = '{
    op:   op,
    ins:  (req_q == REQ_INSERT),
    desc: (req_q == REQ_DUMP_DN),
    code: code_q
  };

  // A shift is never cut short
  a_shift_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && !stat_i.shift_done) |=> (state_q == S_SHIFT))
    else $error("shift left before it finished");

  // An accepted insert on a full table answers full without touching the RAM
  a_full_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && req_in == REQ_INSERT && stat_i.full)
    |=> (state_q == S_RESP && code_q == STS_FULL))
    else $error("full table insert not rejected");

endmodule

// File: rtl/sorted_unique_key_table_top.sv
// Top level of the sorted unique-key table: controller plus datapath.
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Fields
// in       in         in_valid_i/in_stall_o   req_type_i key_i payload_a_i..payload_c_i
// out      out        out_valid_o/out_stall_i status_o key_out_o data_a_o..data_c_o
//                                             position_o last_o
//
// A request is taken only when the block is idle. A search does one RAM read per
// entry in the lower-bound scan. Insert and delete shift only the entries past the
// scan point, one per cycle, so scan and shift together cover the table once. A
// dump gives one beat per cycle while the output is not stalled, after a first
// read. Reset clears the entry count and the control state, not the RAM, which
// needs no clearing. An output stall holds the result register and pauses a dump;
// a new request can be taken while the last beat waits.

module sorted_unique_key_table_top import sukt_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic signed [KEY_W-1:0]  key_i,
  input  logic [DATA_W-1:0]        payload_a_i,
  input  logic [DATA_W-1:0]        payload_b_i,
  input  logic [DATA_W-1:0]        payload_c_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [STS_W-1:0]         status_o,
  output logic signed [KEY_W-1:0]  key_out_o,
  output logic [DATA_W-1:0]        data_a_o,
  output logic [DATA_W-1:0]        data_b_o,
  output logic [DATA_W-1:0]        data_c_o,
  output logic [POS_W-1:0]         position_o,
  output logic                     last_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sukt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  sukt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .key_i       (key_i),
    .payload_a_i (payload_a_i),
    .payload_b_i (payload_b_i),
    .payload_c_i (payload_c_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .key_out_o   (key_out_o),
    .data_a_o    (data_a_o),
    .data_b_o    (data_b_o),
    .data_c_o    (data_c_o),
    .position_o  (position_o),
    .last_o      (last_o)
  );

endmodule

// File: verif/tb_sorted_unique_key_table_top.sv
// Self-checking testbench of the sorted unique-key table top level.
`timescale 1ns / 1ps

module tb_sorted_unique_key_table_top;
  import sukt_pkg::*;

  localparam int unsigned TBL_DEPTH     = CAPACITY_DEF;
  localparam int unsigned KEY_POOL_SIZE = 48;
  localparam int unsigned RANDOM_ITEMS  = 160;
  localparam int unsigned IDLE_PCT      = 37;
  localparam int unsigned BURST_ITEMS   = 60;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned HOLD_FILL     = 24;
  localparam int unsigned SETTLE_CYCLES = 4 * TBL_DEPTH;

  // Request kinds the block ignores
  localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  // One result beat as the block should present it
  typedef struct packed {
    status_e           status;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
    logic [POS_W-1:0]  position;
    logic              last_bit;
  } beat_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [REQ_W-1:0]        req_type_i  = '0;
  logic signed [KEY_W-1:0] key_i       = '0;
  logic [DATA_W-1:0]       payload_a_i = '0;
  logic [DATA_W-1:0]       payload_b_i = '0;
  logic [DATA_W-1:0]       payload_c_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [STS_W-1:0]        status_o;
  logic signed [KEY_W-1:0] key_out_o;
  logic [DATA_W-1:0]       data_a_o;
  logic [DATA_W-1:0]       data_b_o;
  logic [DATA_W-1:0]       data_c_o;
  logic [POS_W-1:0]        position_o;
  logic                    last_o;

  // Shadow copy of the table contents, in ascending key order
  entry_t      sorted_entries [TBL_DEPTH];
  int unsigned entry_total = 0;
  beat_t       expected_beats [$];
  beat_t       want_beat;
  int unsigned fail_count = 0;

  logic signed [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
  bit          tx_gaps_on   = 1'b1;
  bit          rx_gaps_on   = 1'b1;
  int unsigned rx_hold_left = 0;

  sorted_unique_key_table_top #(
    .CAPACITY(TBL_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .key_i      (key_i),
    .payload_a_i(payload_a_i),
    .payload_b_i(payload_b_i),
    .payload_c_i(payload_c_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .key_out_o  (key_out_o),
    .data_a_o   (data_a_o),
    .data_b_o   (data_b_o),
    .data_c_o   (data_c_o),
    .position_o (position_o),
    .last_o     (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Single beat with no entry attached
  function automatic beat_t status_beat(status_e sts);
    beat_t bt = '0;
    bt.status   = sts;
    bt.last_bit = 1'b1;
    return bt;
  endfunction

  // Apply one request to the shadow table and queue the beats it causes
  function automatic void predict_request(logic [REQ_W-1:0] req,
                                          logic signed [KEY_W-1:0] key,
                                          logic [DATA_W-1:0] pa,
                                          logic [DATA_W-1:0] pb,
                                          logic [DATA_W-1:0] pc);
    int unsigned idx;
    int unsigned n;
    int unsigned src;
    bit          hit;
    beat_t       bt;
    if (req > REQ_DUMP_DN) return;
    if (req != REQ_INSERT && entry_total == 0) begin
      expected_beats.push_back(status_beat(STS_EMPTY));
      return;
    end
    // lower bound on the signed key
    idx = 0;
    while (idx < entry_total && $signed(sorted_entries[idx].key) < key) idx++;
    hit = (idx < entry_total) && (sorted_entries[idx].key == key);
    case (req)
      REQ_INSERT: begin
        // fullness wins over the duplicate test
        if (entry_total >= TBL_DEPTH) begin
          expected_beats.push_back(status_beat(STS_FULL));
        end else if (hit) begin
          expected_beats.push_back(status_beat(STS_DUP));
        end else begin
          for (int j = entry_total; j > idx; j--) sorted_entries[j] = sorted_entries[j-1];
          sorted_entries[idx] = '{key: key, a: pa, b: pb, c: pc};
          entry_total++;
          expected_beats.push_back(status_beat(STS_DONE));
        end
      end
      REQ_DELETE, REQ_SEARCH: begin
        if (!hit) begin
          expected_beats.push_back(status_beat(STS_NOTFOUND));
        end else if (req == REQ_SEARCH) begin
          bt     = status_beat(STS_FOUND);
          bt.key = sorted_entries[idx].key;
          bt.a   = sorted_entries[idx].a;
          bt.b   = sorted_entries[idx].b;
          bt.c   = sorted_entries[idx].c;
          expected_beats.push_back(bt);
        end else begin
          for (int j = idx; j + 1 < entry_total; j++) sorted_entries[j] = sorted_entries[j+1];
          entry_total--;
          expected_beats.push_back(status_beat(STS_DONE));
        end
      end
      default: begin
        // dump, ranks always counted in ascending order
        n = (entry_total < MAX_RESULTS) ? entry_total : MAX_RESULTS;
        for (int unsigned j = 0; j < n; j++) begin
          src = (req == REQ_DUMP_UP) ? j : entry_total - 1 - j;
          bt          = status_beat(STS_FOUND);
          bt.key      = sorted_entries[src].key;
          bt.a        = sorted_entries[src].a;
          bt.b        = sorted_entries[src].b;
          bt.c        = sorted_entries[src].c;
          bt.position = POS_W'(src + 1);
          bt.last_bit = (j + 1 == n);
          expected_beats.push_back(bt);
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Requests taken by the block feed the prediction
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      predict_request(req_type_i, key_i, payload_a_i, payload_b_i, payload_c_i);
  end

  // Every accepted result beat is matched against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual status %0d key %0h",
                 $time, status_o, key_out_o);
        fail_count++;
      end else begin
        want_beat = expected_beats.pop_front();
        check_field("status", DATA_W'(want_beat.status), DATA_W'(status_o));
        check_field("key_out", want_beat.key, key_out_o);
        check_field("data_a", want_beat.a, data_a_o);
        check_field("data_b", want_beat.b, data_b_o);
        check_field("data_c", want_beat.c, data_c_o);
        check_field("position", DATA_W'(want_beat.position), DATA_W'(position_o));
        check_field("last", DATA_W'(want_beat.last_bit), DATA_W'(last_o));
      end
    end
  end

  // Result side: random stalls, or a long counted hold when requested
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      out_stall_i  <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_stall_i <= rx_gaps_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Offer one request and return at the edge that takes it
  task automatic send_req(logic [REQ_W-1:0] req, logic signed [KEY_W-1:0] key,
                          logic [DATA_W-1:0] pa, logic [DATA_W-1:0] pb,
                          logic [DATA_W-1:0] pc);
    while (tx_gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    key_i       <= key;
    payload_a_i <= pa;
    payload_b_i <= pb;
    payload_c_i <= pc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_rand(logic [REQ_W-1:0] req, logic signed [KEY_W-1:0] key);
    send_req(req, key, $urandom, $urandom, $urandom);
  endtask

  // Stop offering and wait for every predicted beat
  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_beats.size() != 0);
  endtask

  // Mostly keys that are stored or likely to collide, some fully random
  function automatic logic signed [KEY_W-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50 && entry_total != 0)
      return sorted_entries[$urandom_range(entry_total - 1)].key;
    if (roll < 85) return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Empty table, key extremes, every request kind, lone-entry deletes
  task automatic test_directed();
    send_rand(REQ_SEARCH, 0);
    send_rand(REQ_DELETE, 5);
    send_rand(REQ_DUMP_UP, 0);
    send_rand(REQ_DUMP_DN, 0);
    send_req(REQ_INSERT, KEY_MIN, '1, '1, '1);
    send_rand(REQ_DELETE, KEY_MAX);
    send_rand(REQ_INSERT, KEY_MIN);
    send_req(REQ_INSERT, KEY_MAX, '0, '0, '0);
    send_rand(REQ_INSERT, 0);
    send_rand(REQ_INSERT, -1);
    send_rand(REQ_INSERT, 1);
    send_rand(REQ_SEARCH, KEY_MIN);
    send_rand(REQ_SEARCH, KEY_MAX);
    send_rand(REQ_SEARCH, 2);
    send_rand(REQ_DUMP_UP, 0);
    send_rand(REQ_DUMP_DN, 0);
    for (int r = REQ_SPARE_FIRST; r <= REQ_SPARE_LAST; r++) send_rand(REQ_W'(r), $urandom);
    send_rand(REQ_DELETE, 0);
    send_rand(REQ_DELETE, KEY_MAX);
    send_rand(REQ_DELETE, KEY_MIN);
    send_rand(REQ_DELETE, -1);
    send_rand(REQ_DELETE, 1);
    send_rand(REQ_SEARCH, 1);
    wait_results();
  endtask

  // Fill to capacity, then full-table inserts, full dumps and end deletes
  task automatic test_fill_and_full();
    logic signed [KEY_W-1:0] key_lo;
    logic signed [KEY_W-1:0] key_hi;
    while (entry_total < TBL_DEPTH) begin
      repeat (TBL_DEPTH - entry_total) send_rand(REQ_INSERT, $urandom);
      wait_results();
    end
    key_lo = sorted_entries[0].key;
    key_hi = sorted_entries[TBL_DEPTH-1].key;
    send_rand(REQ_INSERT, key_lo);
    send_rand(REQ_INSERT, $urandom);
    send_rand(REQ_DUMP_UP, 0);
    send_rand(REQ_DUMP_DN, 0);
    send_rand(REQ_SEARCH, key_hi);
    send_rand(REQ_DELETE, key_lo);
    send_rand(REQ_DELETE, key_hi);
    send_rand(REQ_INSERT, key_hi);
    send_rand(REQ_DUMP_DN, 0);
    wait_results();
  endtask

  // Random mix: a burst with no idling on either side, then random gaps
  task automatic test_random_mix();
    int unsigned issued;
    int unsigned roll;
    issued     = 0;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    while (issued < RANDOM_ITEMS) begin
      if (issued == BURST_ITEMS) begin
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll >= 95) begin
        send_rand(REQ_W'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST)), $urandom);
      end else begin
        if (roll < 40)      send_rand(REQ_INSERT, pick_key());
        else if (roll < 65) send_rand(REQ_DELETE, pick_key());
        else if (roll < 85) send_rand(REQ_SEARCH, pick_key());
        else if (roll < 90) send_rand(REQ_DUMP_UP, $urandom);
        else                send_rand(REQ_DUMP_DN, $urandom);
        issued++;
      end
      // occasional full drain between requests
      if ($urandom_range(49) == 0) wait_results();
    end
    wait_results();
  endtask

  // Long output hold while requests keep coming, so the input backs up
  task automatic test_output_hold();
    while (entry_total < HOLD_FILL) begin
      repeat (HOLD_FILL - entry_total) send_rand(REQ_INSERT, $urandom);
      wait_results();
    end
    tx_gaps_on   = 1'b0;
    rx_hold_left = HOLD_CYCLES;
    send_rand(REQ_DUMP_UP, 0);
    send_rand(REQ_DUMP_DN, 0);
    send_rand(REQ_SEARCH, pick_key());
    send_rand(REQ_DUMP_UP, 0);
    send_rand(REQ_INSERT, pick_key());
    send_rand(REQ_DUMP_DN, 0);
    tx_gaps_on = 1'b1;
    wait_results();
  endtask

  initial begin
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 0;
    key_pool[3] = -1;
    for (int i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_and_full();
    test_random_mix();
    test_output_hold();
    // let any ignored request finish before the final verdict
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_beats.size() != 0) begin
      $display("%0t: results missing, expected %0d more beats actual 0",
               $time, expected_beats.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sorted_unique_key_table_top.f
rtl/sukt_pkg.sv
rtl/sukt_ram.sv
rtl/sukt_dp.sv
rtl/sukt_ctrl.sv
rtl/sorted_unique_key_table_top.sv
verif/tb_sorted_unique_key_table_top.sv
